>>> hdl/ktrie_pkg.sv
package ktrie_pkg;

  localparam int SYMBOLS        = 37;
  localparam int LETTERS        = 26;
  localparam int SYM_DIGIT_BASE = 26;
  localparam int SYM_UNDERSCORE = 36;
  localparam int SYM_W          = 6;
  localparam int TAG_W          = 11;
  localparam int INDEX_W        = 10;

  localparam logic [TAG_W-1:0] NO_WORD = {TAG_W{1'b1}};

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [2:0] STATUS_INSERTED  = 3'd0;
  localparam logic [2:0] STATUS_FOUND     = 3'd1;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
  localparam logic [2:0] STATUS_BAD_CHAR  = 3'd3;
  localparam logic [2:0] STATUS_POOL_FULL = 3'd4;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_BAD_CHAR = 2'd1;
  localparam logic [1:0] FAULT_POOL     = 2'd2;
  localparam logic [1:0] FAULT_MISSING  = 2'd3;

  typedef struct packed {
    logic                 op;
    logic [7:0]           char_code;
    logic                 is_last;
    logic [INDEX_W-1:0]   keyword_index;
  } item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [INDEX_W-1:0]   found_index;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic resolve;
    logic tag_finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic walk;
    logic need_tag;
    logic clear_last;
  } dp_stat_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
  } sym_t;

  function automatic sym_t symbol_of(input logic [7:0] c);
    sym_t       s;
    logic [7:0] lc;
    s.valid = 1'b0;
    s.sym   = '0;
    lc      = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    if (lc == 8'h5F) begin
      s.valid = 1'b1;
      s.sym   = SYM_W'(SYM_UNDERSCORE);
    end else if (lc >= 8'h61 && lc <= 8'h7A) begin
      s.valid = 1'b1;
      s.sym   = SYM_W'(lc - 8'h61);
    end else if (lc >= 8'h30 && lc <= 8'h39) begin
      s.valid = 1'b1;
      s.sym   = SYM_W'(lc - 8'h30) + SYM_W'(SYM_DIGIT_BASE);
    end
    return s;
  endfunction

  function automatic logic [2:0] fault_status(input logic op, input logic [1:0] fault);
    logic [2:0] st;
    st = STATUS_NOT_FOUND;
    if (op == OP_INSERT) begin
      unique case (fault)
        FAULT_BAD_CHAR: st = STATUS_BAD_CHAR;
        FAULT_POOL:     st = STATUS_POOL_FULL;
        FAULT_MISSING:  st = STATUS_NOT_FOUND;
        default:        st = STATUS_INSERTED;
      endcase
    end
    return st;
  endfunction

endpackage

>>> hdl/ktrie_ctrl.sv
module ktrie_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ktrie_pkg::dp_stat_t stat,
  output ktrie_pkg::ctl_t     ctl,
  output logic                busy
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHILD,
    S_TAG
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl            = '0;
    ctl.clear_en   = (state == S_CLEAR);
    ctl.accept     = (state == S_IDLE) && start;
    ctl.resolve    = (state == S_CHILD);
    ctl.tag_finish = (state == S_TAG);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:  if (start && stat.walk) state_next = S_CHILD;
      S_CHILD: state_next = stat.need_tag ? S_TAG : S_IDLE;
      S_TAG:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

>>> hdl/ktrie_datapath.sv
module ktrie_datapath #(
  parameter int NODE_POOL  = 1024,
  parameter int WORD_SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  ktrie_pkg::ctl_t     ctl,
  input  ktrie_pkg::item_t    item,
  output ktrie_pkg::dp_stat_t stat,
  output logic                done,
  output ktrie_pkg::result_t  result
);

  localparam int NW          = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int FW          = $clog2(NODE_POOL + 1);
  localparam int CHILD_DEPTH = NODE_POOL * ktrie_pkg::SYMBOLS;
  localparam int CAW         = $clog2(CHILD_DEPTH);
  localparam int TW          = ktrie_pkg::TAG_W;
  localparam int IW          = ktrie_pkg::INDEX_W;

  logic [NW-1:0] child_mem [CHILD_DEPTH];
  logic [TW-1:0] tag_mem   [NODE_POOL];

  logic [NW-1:0]  cur_node;
  logic [1:0]     fault;
  logic [FW-1:0]  free_node;
  logic [CAW-1:0] clr_cnt;

  logic           op_q;
  logic           last_q;
  logic [IW-1:0]  kidx_q;
  logic [CAW-1:0] slot_q;
  logic [NW-1:0]  child_q;
  logic [TW-1:0]  tag_q;

  ktrie_pkg::sym_t sym;
  logic [CAW-1:0]  rd_addr;
  logic            missing;
  logic            pool_full;
  logic            alloc;
  logic [1:0]      new_fault;
  logic [NW-1:0]   step_node;
  logic            tag_write;
  logic            child_wr;
  logic [CAW-1:0]  child_wr_addr;
  logic [NW-1:0]   child_wr_data;
  logic            tag_found;

  always_comb begin
    sym     = ktrie_pkg::symbol_of(item.char_code);
    // node * 37 as shift-add
    rd_addr = CAW'({cur_node, 5'b0}) + CAW'({cur_node, 2'b0}) + CAW'(cur_node)
            + CAW'(sym.sym);

    missing   = (child_q == '0);
    pool_full = (free_node == FW'(NODE_POOL));
    alloc     = missing && (op_q == ktrie_pkg::OP_INSERT) && !pool_full;
    if (!missing)
      new_fault = ktrie_pkg::FAULT_NONE;
    else if (op_q == ktrie_pkg::OP_LOOKUP)
      new_fault = ktrie_pkg::FAULT_MISSING;
    else if (pool_full)
      new_fault = ktrie_pkg::FAULT_POOL;
    else
      new_fault = ktrie_pkg::FAULT_NONE;
    step_node = missing ? free_node[NW-1:0] : child_q;
    tag_write = last_q && (op_q == ktrie_pkg::OP_INSERT)
             && (new_fault == ktrie_pkg::FAULT_NONE);

    stat.walk       = (fault == ktrie_pkg::FAULT_NONE) && sym.valid;
    stat.need_tag   = last_q && (op_q == ktrie_pkg::OP_LOOKUP)
                   && (new_fault == ktrie_pkg::FAULT_NONE);
    stat.clear_last = (clr_cnt == CAW'(CHILD_DEPTH - 1));

    child_wr      = ctl.clear_en || (ctl.resolve && alloc);
    child_wr_addr = ctl.clear_en ? clr_cnt : slot_q;
    child_wr_data = ctl.clear_en ? '0 : free_node[NW-1:0];

    tag_found = (tag_q != ktrie_pkg::NO_WORD) && (32'(tag_q) < 32'(WORD_SLOTS));
  end

  always_ff @(posedge clk) begin
    if (child_wr) child_mem[child_wr_addr] <= child_wr_data;
    if (ctl.accept) child_q <= child_mem[rd_addr];
  end

  // a fresh node gets no-word, the final node of an insert gets its index
  always_ff @(posedge clk) begin
    if (ctl.resolve && (alloc || tag_write))
      tag_mem[step_node] <= tag_write ? TW'(kidx_q) : ktrie_pkg::NO_WORD;
    if (ctl.resolve) tag_q <= tag_mem[step_node];
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_q   <= item.op;
      last_q <= item.is_last;
      kidx_q <= item.keyword_index;
      slot_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_node  <= '0;
      fault     <= ktrie_pkg::FAULT_NONE;
      free_node <= FW'(1);
      clr_cnt   <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.clear_en) clr_cnt <= clr_cnt + CAW'(1);

      if (ctl.accept && !stat.walk) begin
        if (item.is_last) begin
          done               <= 1'b1;
          result.status      <= ktrie_pkg::fault_status(item.op,
                                  (fault == ktrie_pkg::FAULT_NONE) ?
                                  ktrie_pkg::FAULT_BAD_CHAR : fault);
          result.found_index <= '0;
          cur_node           <= '0;
          fault              <= ktrie_pkg::FAULT_NONE;
        end else if (fault == ktrie_pkg::FAULT_NONE) begin
          fault <= ktrie_pkg::FAULT_BAD_CHAR;
        end
      end

      if (ctl.resolve) begin
        if (alloc) free_node <= free_node + FW'(1);
        if (last_q) begin
          cur_node <= '0;
          fault    <= ktrie_pkg::FAULT_NONE;
          if (!stat.need_tag) begin
            done               <= 1'b1;
            result.status      <= ktrie_pkg::fault_status(op_q, new_fault);
            result.found_index <= '0;
          end
        end else begin
          fault <= new_fault;
          if (new_fault == ktrie_pkg::FAULT_NONE) cur_node <= step_node;
        end
      end

      if (ctl.tag_finish) begin
        done               <= 1'b1;
        result.status      <= tag_found ? ktrie_pkg::STATUS_FOUND :
                                          ktrie_pkg::STATUS_NOT_FOUND;
        result.found_index <= tag_found ? tag_q[IW-1:0] : '0;
      end
    end
  end

endmodule

>>> hdl/keyword_trie_engine_unit.sv
// channel   | ports                  | handshake
// ----------+------------------------+-------------------------------------
// item in   | start, busy, item      | taken on a clock edge with start & !busy
// result    | done, result           | done high for one cycle, cannot stall
//
// after reset busy stays high while the child store
// is swept to zero one entry per cycle.
// a character with a fault already in its word, or a bad character: taken with the controller staying idle.
// a walking character: S_CHILD follows, for the registered child store read.
// last lookup character whose child exists: S_TAG follows S_CHILD, for the tag read.
// the result strobe comes in the cycle after the last item's final step.
module keyword_trie_engine_unit #(
  parameter int NODE_POOL  = 1024,
  parameter int WORD_SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ktrie_pkg::item_t   item,
  output logic               busy,
  output logic               done,
  output ktrie_pkg::result_t result
);

  ktrie_pkg::ctl_t     ctl;
  ktrie_pkg::dp_stat_t stat;

  ktrie_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  ktrie_datapath #(
    .NODE_POOL  (NODE_POOL),
    .WORD_SLOTS (WORD_SLOTS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (item),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

>>> tb/keyword_trie_checker.sv
module keyword_trie_checker
  import ktrie_pkg::*;
#(
  parameter int NODE_POOL  = 1024,
  parameter int WORD_SLOTS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  item_t      item,
  input  logic       done,
  input  result_t    result,
  output int         mismatches,
  output int         outstanding,
  output int         results_checked,
  output logic [4:0] status_seen,
  output logic       pool_ran_out
);
  timeunit 1ns;
  timeprecision 1ps;

  int               trie_child [0:NODE_POOL*SYMBOLS-1];
  logic [TAG_W-1:0] node_tag [0:NODE_POOL-1];
  int               walk_node;
  int               next_free;
  logic [1:0]       walk_fault;
  result_t          expected_results [$];

  function automatic int symbol_code(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61;
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + SYM_DIGIT_BASE;
    if (c == 8'h5F) return SYM_UNDERSCORE;
    return -1;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endtask

  task automatic clear_trie();
    foreach (trie_child[i]) trie_child[i] = 0;
    foreach (node_tag[i]) node_tag[i] = NO_WORD;
    walk_node  = 0;
    walk_fault = FAULT_NONE;
    next_free  = 1;
    expected_results.delete();
  endtask

  task automatic apply_char(input item_t it);
    int      sym;
    int      slot;
    int      child;
    result_t want;
    // the first fault in a keyword freezes the walk until its last character
    if (walk_fault == FAULT_NONE) begin
      sym = symbol_code(it.char_code);
      if (sym < 0) begin
        walk_fault = FAULT_BAD_CHAR;
      end else begin
        slot  = walk_node * SYMBOLS + sym;
        child = trie_child[slot];
        if (child == 0) begin
          if (it.op == OP_LOOKUP) begin
            walk_fault = FAULT_MISSING;
          end else if (next_free >= NODE_POOL) begin
            walk_fault   = FAULT_POOL;
            pool_ran_out = 1'b1;
          end else begin
            child = next_free;
            next_free++;
            node_tag[child]  = NO_WORD;
            trie_child[slot] = child;
          end
        end
        if (walk_fault == FAULT_NONE) walk_node = child;
      end
    end
    if (it.is_last) begin
      want.found_index = '0;
      if (it.op == OP_INSERT) begin
        case (walk_fault)
          FAULT_BAD_CHAR: want.status = STATUS_BAD_CHAR;
          FAULT_POOL:     want.status = STATUS_POOL_FULL;
          FAULT_MISSING:  want.status = STATUS_NOT_FOUND;
          default: begin
            node_tag[walk_node] = {1'b0, it.keyword_index};
            want.status         = STATUS_INSERTED;
          end
        endcase
      end else if (walk_fault == FAULT_NONE && node_tag[walk_node] != NO_WORD &&
                   node_tag[walk_node] < WORD_SLOTS) begin
        want.status      = STATUS_FOUND;
        want.found_index = node_tag[walk_node][INDEX_W-1:0];
      end else begin
        want.status = STATUS_NOT_FOUND;
      end
      expected_results.push_back(want);
      walk_node  = 0;
      walk_fault = FAULT_NONE;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    results_checked++;
    if (got.status <= STATUS_POOL_FULL) status_seen[got.status] = 1'b1;
    if (expected_results.size() == 0) begin
      report($sformatf("result %0d (status %0d) with nothing outstanding",
                       results_checked, got.status));
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, expected %0d",
                         results_checked, got.status, want.status));
      if (got.found_index !== want.found_index)
        report($sformatf("result %0d found_index %0d, expected %0d",
                         results_checked, got.found_index, want.found_index));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatches      = 0;
      results_checked = 0;
      status_seen     = '0;
      pool_ran_out    = 1'b0;
      clear_trie();
    end else begin
      if (done) check_result(result);
      if (start && !busy) apply_char(item);
    end
    outstanding = expected_results.size();
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ktrie_pkg::*;

  localparam int NODE_POOL      = 1024;
  localparam int WORD_SLOTS     = 1024;
  localparam int MAX_LEN        = 16;
  localparam int KNOWN_SLOTS    = 128;
  localparam int WATCHDOG_LIMIT = 4 * NODE_POOL * SYMBOLS;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       done;
  item_t      item;
  result_t    result;
  int         mismatches;
  int         outstanding;
  int         results_checked;
  logic [4:0] status_seen;
  logic       pool_ran_out;

  logic [7:0] key_chars [0:MAX_LEN-1];
  logic       key_ops [0:MAX_LEN-1];
  logic [7:0] known_chars [0:KNOWN_SLOTS-1][0:MAX_LEN-1];
  int         known_len [0:KNOWN_SLOTS-1];
  int         known_count = 0;
  int         chars_sent = 0;
  int         keys_sent = 0;
  int         quiet_cycles = 0;
  bit         steady = 1'b0;

  keyword_trie_engine_unit #(
    .NODE_POOL (NODE_POOL),
    .WORD_SLOTS(WORD_SLOTS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  keyword_trie_checker #(
    .NODE_POOL (NODE_POOL),
    .WORD_SLOTS(WORD_SLOTS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (item),
    .done           (done),
    .result         (result),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .status_seen    (status_seen),
    .pool_ran_out   (pool_ran_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // the sweep of the child store after reset is the longest quiet stretch
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 10);
    return $urandom_range(11, MAX_LEN);
  endfunction

  function automatic logic [7:0] valid_char();
    int s;
    s = $urandom_range(0, SYMBOLS - 1);
    if (s < LETTERS) return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(s);
    if (s < SYM_UNDERSCORE) return 8'h30 + 8'(s - SYM_DIGIT_BASE);
    return 8'h5F;
  endfunction

  // bytes just outside each accepted range turn up more often than chance gives
  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: return 8'h2F;
      1: return 8'h3A;
      2: return 8'h40;
      3: return 8'h5B;
      4: return 8'h60;
      5: return 8'h7B;
      default: begin
        c = 8'($urandom);
        while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F)
          c = 8'($urandom);
        return c;
      end
    endcase
  endfunction

  function automatic logic [7:0] any_case(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
      return c ^ {2'b00, 1'($urandom_range(0, 1)), 5'b00000};
    return c;
  endfunction

  function automatic int load_text(input string s);
    for (int i = 0; i < s.len(); i++) key_chars[i] = s[i];
    return s.len();
  endfunction

  function automatic int random_key(input int len);
    for (int i = 0; i < len; i++) key_chars[i] = valid_char();
    return len;
  endfunction

  function automatic void remember_key(input int len);
    int slot;
    if (known_count < KNOWN_SLOTS) begin
      slot = known_count;
      known_count++;
    end else begin
      slot = $urandom_range(0, KNOWN_SLOTS - 1);
    end
    for (int i = 0; i < len; i++) known_chars[slot][i] = key_chars[i];
    known_len[slot] = len;
  endfunction

  function automatic int recall_key();
    int slot;
    if (known_count == 0) return random_key(pick_len());
    slot = $urandom_range(0, known_count - 1);
    for (int i = 0; i < known_len[slot]; i++) key_chars[i] = any_case(known_chars[slot][i]);
    return known_len[slot];
  endfunction

  function automatic void set_ops(input logic op);
    for (int i = 0; i < MAX_LEN; i++) key_ops[i] = op;
  endfunction

  task automatic send_char(input logic op, input logic [7:0] c, input logic last,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    item  = '{op: op, char_code: c, is_last: last, keyword_index: idx};
    do @(posedge clk); while (busy);
    chars_sent++;
  endtask

  task automatic send_key(input int len, input logic [INDEX_W-1:0] tag);
    for (int i = 0; i < len; i++)
      send_char(key_ops[i], key_chars[i], i == len - 1,
                (i == len - 1) ? tag : INDEX_W'($urandom));
    keys_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic random_keyword();
    int kind;
    int len;
    kind   = $urandom_range(0, 99);
    steady = ($urandom_range(0, 3) == 0);
    if (kind < 33) begin
      len = random_key(pick_len());
      set_ops(OP_INSERT);
      send_key(len, INDEX_W'($urandom));
      remember_key(len);
    end else if (kind < 43) begin
      // re-insert retags an existing keyword
      len = recall_key();
      set_ops(OP_INSERT);
      send_key(len, INDEX_W'($urandom));
    end else if (kind < 68) begin
      len = recall_key();
      set_ops(OP_LOOKUP);
      send_key(len, INDEX_W'($urandom));
    end else if (kind < 80) begin
      // prefix or one character longer: mostly untagged or missing paths
      len = recall_key();
      if (len > 1 && $urandom_range(0, 1)) begin
        len = $urandom_range(1, len - 1);
      end else if (len < MAX_LEN) begin
        key_chars[len] = valid_char();
        len++;
      end
      set_ops(OP_LOOKUP);
      send_key(len, INDEX_W'($urandom));
    end else if (kind < 90) begin
      len = $urandom_range(0, 1) ? recall_key() : random_key(pick_len());
      key_chars[$urandom_range(0, len - 1)] = bad_char();
      set_ops(1'($urandom));
      send_key(len, INDEX_W'($urandom));
    end else begin
      len = recall_key();
      for (int i = 0; i < len; i++) key_ops[i] = 1'($urandom);
      send_key(len, INDEX_W'($urandom));
    end
    if ($urandom_range(0, 99) < 3) drain();
  endtask

  initial begin
    int len;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    set_ops(OP_INSERT);
    len = load_text("a");
    send_key(len, 10'd0);
    remember_key(len);
    set_ops(OP_LOOKUP);
    send_key(load_text("A"), 10'd0);
    set_ops(OP_INSERT);
    len = load_text("Zz_9");
    send_key(len, 10'd1023);
    remember_key(len);
    set_ops(OP_LOOKUP);
    send_key(load_text("zZ_9"), 10'd0);
    // node on the path but never tagged
    send_key(load_text("zz"), 10'd0);
    set_ops(OP_INSERT);
    send_key(load_text("A"), 10'd512);
    set_ops(OP_LOOKUP);
    send_key(load_text("a"), 10'd0);
    // bad character after a fresh node: the node stays, untagged
    set_ops(OP_INSERT);
    send_key(load_text("0@"), 10'd5);
    set_ops(OP_LOOKUP);
    send_key(load_text("0"), 10'd0);
    send_key(load_text("q"), 10'd0);
    key_chars[0] = 8'hFF;
    send_key(1, 10'd0);
    // missing path from a lookup character, finished by an insert
    len = load_text("xy");
    key_ops[0] = OP_LOOKUP;
    key_ops[1] = OP_INSERT;
    send_key(len, 10'd77);
    set_ops(OP_INSERT);
    key_chars[0] = 8'h00;
    send_key(1, 10'h155);
    drain();

    while (chars_sent < 450) random_keyword();
    drain();

    // long fresh keywords run the node pool dry
    for (int k = 0; k < 70; k++) begin
      steady = ($urandom_range(0, 3) == 0);
      len    = random_key(MAX_LEN);
      set_ops(OP_INSERT);
      send_key(len, INDEX_W'($urandom));
      remember_key(len);
    end
    repeat (25) random_keyword();
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d characters in %0d keywords, %0d results compared",
             chars_sent, keys_sent, results_checked);
    $display("status codes seen %b, node pool %s", status_seen,
             pool_ran_out ? "ran out" : "never ran out");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
